### rtl/fhmd_pkg.sv
// Types and constants shared by the flag-header message deframer.
`default_nettype none
package fhmd_pkg;

   localparam logic [7:0] UpperNibbleMask = 8'hF0;
   localparam logic [7:0] AllOnesByte     = 8'hFF;
   localparam logic [15:0] MaxMessagesReset = 16'hFFFF;
   localparam logic [15:0] CountLimit       = 16'hFFFF;

   localparam logic KindMessage = 1'b0;
   localparam logic KindSummary = 1'b1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_buffer;
   } req_beat_type;

   typedef struct packed {
      logic        kind;
      logic        has_message_flags;
      logic [7:0]  message_flags;
      logic [7:0]  protocol_id;
      logic [15:0] payload_offset;
      logic [15:0] payload_length;
      logic [15:0] message_total;
      logic [15:0] consumed_bytes;
      logic        last;
   } rsp_beat_type;

   typedef struct packed {
      logic         first_valid;
      logic         second_valid;
      rsp_beat_type first_beat;
      rsp_beat_type second_beat;
   } push_type;

endpackage
`default_nettype wire

### rtl/fhmd_parser.sv
// Input register, per-byte header/payload parser and sticky message state.
`default_nettype none
module fhmd_parser #(
   parameter int unsigned MAX_BUFFER_BYTES = 65535
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire fhmd_pkg::req_beat_type req_beat,
   input  wire logic                  csr_write_enable,
   input  wire logic [15:0]           csr_write_data,
   input  wire logic                  room_for_two,
   output fhmd_pkg::push_type         push
);

   localparam logic [15:0] MaxPos = 16'(MAX_BUFFER_BYTES);

   typedef enum logic [2:0] {
      PH_FLAG, PH_MF, PH_SIZE_HI, PH_SIZE_LO, PH_PROTO, PH_PORT, PH_PAYLOAD, PH_STOP
   } phase_type;

   logic                   in_valid_ff, in_valid_in;
   fhmd_pkg::req_beat_type in_beat_ff;
   logic [15:0]            max_messages_ff;

   phase_type   phase_ff, phase_in;
   logic [15:0] position_ff, position_in;
   logic [15:0] message_start_ff, message_start_in;
   logic [3:0]  pending_ff, pending_in;
   logic        seen_mf_ff, seen_mf_in;
   logic [7:0]  held_mf_ff, held_mf_in;
   logic        seen_size_ff, seen_size_in;
   logic [15:0] held_size_ff, held_size_in;
   logic [7:0]  held_proto_ff, held_proto_in;
   logic [15:0] payload_left_ff, payload_left_in;
   logic [15:0] payload_begin_ff, payload_begin_in;
   logic [15:0] count_ff, count_in;

   logic process;
   logic [7:0] b;
   logic [15:0] next_pos;
   phase_type ph;
   logic do_adv;
   logic do_finish;
   logic [3:0] pend_src;
   logic msg_fire;
   fhmd_pkg::rsp_beat_type msg_beat;
   fhmd_pkg::rsp_beat_type sum_beat;

   assign process   = in_valid_ff && room_for_two;
   assign req_ready = !in_valid_ff || process;
   assign in_valid_in = req_valid ? 1'b1 : (in_valid_ff && !process);
   assign b = in_beat_ff.data_byte;
   assign next_pos = position_ff + 16'd1;

   always_comb begin
      phase_in         = phase_ff;
      message_start_in = message_start_ff;
      pending_in       = pending_ff;
      seen_mf_in       = seen_mf_ff;
      held_mf_in       = held_mf_ff;
      seen_size_in     = seen_size_ff;
      held_size_in     = held_size_ff;
      held_proto_in    = held_proto_ff;
      payload_left_in  = payload_left_ff;
      payload_begin_in = payload_begin_ff;
      count_in         = count_ff;
      do_adv    = 1'b0;
      do_finish = 1'b0;
      pend_src  = pending_ff;
      msg_fire  = 1'b0;

      ph = phase_ff;
      if (phase_ff != PH_STOP && position_ff >= MaxPos) begin
         if (phase_ff == PH_FLAG) begin
            message_start_in = position_ff;
         end
         ph = PH_STOP;
      end
      phase_in = ph;

      unique case (ph)
         PH_FLAG: begin
            message_start_in = position_ff;
            if ((b & fhmd_pkg::UpperNibbleMask) != 8'd0 || (!b[1] && !seen_size_ff)) begin
               phase_in = PH_STOP;
            end else begin
               pend_src = b[3:0];
               do_adv   = 1'b1;
            end
         end
         PH_MF: begin
            held_mf_in = b;
            seen_mf_in = 1'b1;
            do_adv     = 1'b1;
         end
         PH_SIZE_HI: begin
            held_size_in = {b, held_size_ff[7:0]};
            phase_in     = PH_SIZE_LO;
         end
         PH_SIZE_LO: begin
            held_size_in = {held_size_ff[15:8], b};
            seen_size_in = 1'b1;
            do_adv       = 1'b1;
         end
         PH_PROTO: begin
            held_proto_in = b;
            do_adv        = 1'b1;
         end
         PH_PORT: begin
            do_adv = 1'b1;
         end
         PH_PAYLOAD: begin
            payload_left_in = (payload_left_ff != 16'd0) ? payload_left_ff - 16'd1 : 16'd0;
            if (payload_left_in == 16'd0) begin
               do_finish = 1'b1;
            end
         end
         PH_STOP: begin
         end
      endcase

      if (do_adv) begin
         pending_in = pend_src;
         priority if (pend_src[0]) begin
            pending_in[0] = 1'b0;
            phase_in      = PH_MF;
         end else if (pend_src[1]) begin
            pending_in[1] = 1'b0;
            phase_in      = PH_SIZE_HI;
         end else if (pend_src[2]) begin
            pending_in[2] = 1'b0;
            phase_in      = PH_PROTO;
         end else if (pend_src[3]) begin
            pending_in[3] = 1'b0;
            phase_in      = PH_PORT;
         end else begin
            payload_begin_in = next_pos;
            payload_left_in  = held_size_in;
            if (held_size_in == 16'd0) begin
               do_finish = 1'b1;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
      end

      if (do_finish) begin
         msg_fire = count_ff < max_messages_ff;
         if (count_ff < fhmd_pkg::CountLimit) begin
            count_in = count_ff + 16'd1;
         end
         phase_in         = PH_FLAG;
         message_start_in = next_pos;
      end

      position_in = (position_ff < MaxPos) ? next_pos : position_ff;

      msg_beat = '0;
      msg_beat.kind              = fhmd_pkg::KindMessage;
      msg_beat.has_message_flags = seen_mf_in;
      msg_beat.message_flags     = held_mf_in;
      msg_beat.protocol_id       = held_proto_in;
      msg_beat.payload_offset    = payload_begin_in;
      msg_beat.payload_length    = held_size_in;
      msg_beat.last              = !in_beat_ff.end_of_buffer;

      sum_beat = '0;
      sum_beat.kind           = fhmd_pkg::KindSummary;
      sum_beat.message_total  = count_in;
      sum_beat.consumed_bytes = message_start_in;
      sum_beat.last           = 1'b1;

      push = '0;
      if (process) begin
         if (msg_fire) begin
            push.first_valid  = 1'b1;
            push.first_beat   = msg_beat;
            push.second_valid = in_beat_ff.end_of_buffer;
            push.second_beat  = sum_beat;
         end else if (in_beat_ff.end_of_buffer) begin
            push.first_valid = 1'b1;
            push.first_beat  = sum_beat;
         end
      end

      if (in_beat_ff.end_of_buffer) begin
         phase_in         = PH_FLAG;
         position_in      = 16'd0;
         message_start_in = 16'd0;
         pending_in       = 4'd0;
         seen_mf_in       = 1'b0;
         held_mf_in       = 8'd0;
         seen_size_in     = 1'b0;
         held_size_in     = 16'd0;
         held_proto_in    = 8'd0;
         payload_left_in  = 16'd0;
         payload_begin_in = 16'd0;
         count_in         = 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         in_beat_ff <= req_beat;
      end
      if (reset) begin
         in_valid_ff      <= 1'b0;
         max_messages_ff  <= fhmd_pkg::MaxMessagesReset;
         phase_ff         <= PH_FLAG;
         position_ff      <= 16'd0;
         message_start_ff <= 16'd0;
         pending_ff       <= 4'd0;
         seen_mf_ff       <= 1'b0;
         held_mf_ff       <= 8'd0;
         seen_size_ff     <= 1'b0;
         held_size_ff     <= 16'd0;
         held_proto_ff    <= 8'd0;
         payload_left_ff  <= 16'd0;
         payload_begin_ff <= 16'd0;
         count_ff         <= 16'd0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= in_valid_in;
         end
         if (csr_write_enable) begin
            max_messages_ff <= csr_write_data;
         end
         if (process) begin
            phase_ff         <= phase_in;
            position_ff      <= position_in;
            message_start_ff <= message_start_in;
            pending_ff       <= pending_in;
            seen_mf_ff       <= seen_mf_in;
            held_mf_ff       <= held_mf_in;
            seen_size_ff     <= seen_size_in;
            held_size_ff     <= held_size_in;
            held_proto_ff    <= held_proto_in;
            payload_left_ff  <= payload_left_in;
            payload_begin_ff <= payload_begin_in;
            count_ff         <= count_in;
         end
      end
   end

endmodule
`default_nettype wire

### rtl/fhmd_rsp_queue.sv
// Four-entry result queue that takes up to two beats per cycle.
`default_nettype none
module fhmd_rsp_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire fhmd_pkg::push_type push,
   output logic                    room_for_two,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output fhmd_pkg::rsp_beat_type  rsp_beat
);

   fhmd_pkg::rsp_beat_type entry_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       pop;
   logic [1:0] push_count;

   assign rsp_valid    = count_ff != 3'd0;
   assign rsp_beat     = entry_ff[rd_ptr_ff];
   assign room_for_two = count_ff <= 3'd2;
   assign pop          = rsp_valid && rsp_ready;
   assign push_count   = {1'b0, push.first_valid} + {1'b0, push.second_valid};
   assign wr_ptr_in    = wr_ptr_ff + push_count;
   assign rd_ptr_in    = rd_ptr_ff + {1'b0, pop};
   assign count_in     = count_ff + {1'b0, push_count} - {2'b00, pop};

   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         entry_ff[wr_ptr_ff] <= push.first_beat;
      end
      if (push.second_valid) begin
         entry_ff[wr_ptr_ff + 2'd1] <= push.second_beat;
      end
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

### rtl/flag_header_message_deframer_top.sv
// Top level of the flag-header message deframer.
// Takes one buffer byte per cycle and tiles the buffer into flag-header messages; a
// message result is emitted when its payload (or, if empty, its header) completes, for
// at most max_messages per buffer, and the final byte of a buffer adds a summary
// beat. Each accepted byte is held in the input register and passes through the parser
// into a four-entry result queue, so the sustained rate is one byte per cycle; a byte
// yielding a message and a summary takes two result beats, and the input stalls only
// while the queue holds more than two beats. The user must write max_messages
// on csr_write_enable/csr_write_data only while the block is idle; the block does not enforce it.
`default_nettype none
module flag_header_message_deframer_top #(
   parameter int unsigned MAX_BUFFER_BYTES = 65535
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire fhmd_pkg::req_beat_type req_beat,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output fhmd_pkg::rsp_beat_type      rsp_beat,
   input  wire logic                   csr_write_enable,
   input  wire logic [15:0]            csr_write_data
);

   fhmd_pkg::push_type push;
   logic               room_for_two;

   fhmd_parser #(
      .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
   ) u_parser (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_beat         (req_beat),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .room_for_two     (room_for_two),
      .push             (push)
   );

   fhmd_rsp_queue u_rsp_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .room_for_two (room_for_two),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_beat     (rsp_beat)
   );

endmodule
`default_nettype wire
